FILE: design/sos_pkg.sv
// ----------------------------------------------------------------------------
// sos_pkg: shared types and widths of the sphere occlusion test
// Field widths of the beats and the derived widths of every arithmetic stage.
// ----------------------------------------------------------------------------
package sos_pkg;

  localparam int CoordWidth  = 16;
  localparam int RadiusWidth = 15;
  localparam logic [RadiusWidth-1:0] RadiusReset = RadiusWidth'(256);

  localparam int DifWidth  = CoordWidth + 1;
  localparam int RrWidth   = 2 * RadiusWidth;
  localparam int AWidth    = 2 * CoordWidth + 3;
  localparam int HWidth    = 2 * CoordWidth + 3;
  localparam int CWidth    = ((2 * CoordWidth > RrWidth) ? 2 * CoordWidth : RrWidth) + 3;
  localparam int HhWidth   = 2 * HWidth;
  localparam int AcWidth   = AWidth + CWidth;
  localparam int DiscWidth = ((HhWidth > AcWidth) ? HhWidth : AcWidth) + 1;
  localparam int RootWidth = (DiscWidth + 1) / 2;
  localparam int SqWidth   = 2 * RootWidth;
  localparam int NumWidth0 = (RootWidth + 1 > HWidth) ? RootWidth + 1 : HWidth;
  localparam int NumWidth  = ((NumWidth0 > AWidth) ? NumWidth0 : AWidth) + 2;

  typedef struct packed {
    logic signed [CoordWidth-1:0] from_x;
    logic signed [CoordWidth-1:0] from_y;
    logic signed [CoordWidth-1:0] from_z;
    logic signed [CoordWidth-1:0] to_x;
    logic signed [CoordWidth-1:0] to_y;
    logic signed [CoordWidth-1:0] to_z;
  } in_t;

  typedef struct packed {
    logic passes;
    logic misses_sphere;
  } out_t;

  // Values that ride alongside the square root pipeline.
  typedef struct packed {
    logic signed [HWidth-1:0] h;
    logic signed [AWidth-1:0] a;
    logic                     neg;
    logic                     azero;
  } side_t;

endpackage

FILE: design/sos_front.sv
// ----------------------------------------------------------------------------
// sos_front: dot products and discriminant
// Five register stages: differences, products, sums, squares, discriminant.
// ----------------------------------------------------------------------------
module sos_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  input  sos_pkg::in_t                    item_i,
  input  logic [sos_pkg::RadiusWidth-1:0] radius_i,
  output logic                            valid_o,
  output logic [sos_pkg::SqWidth-1:0]     disc_o,
  output sos_pkg::side_t                  side_o
);
  import sos_pkg::*;

  logic [4:0] vld_q;

  logic signed [DifWidth-1:0]   d_q  [3];
  logic signed [CoordWidth-1:0] s_q  [3];
  logic [RadiusWidth-1:0]       r_q;

  logic signed [2*DifWidth-1:0]        dd_q [3];
  logic signed [DifWidth+CoordWidth-1:0] ds_q [3];
  logic signed [2*CoordWidth-1:0]      ss_q [3];
  logic [RrWidth-1:0]                  rr_q;

  logic signed [AWidth-1:0] a_q;
  logic signed [HWidth-1:0] h_q;
  logic signed [CWidth-1:0] c_q;

  logic signed [HhWidth-1:0] hh_q;
  logic signed [AcWidth-1:0] ac_q;
  logic signed [AWidth-1:0]  a4_q;
  logic signed [HWidth-1:0]  h4_q;

  logic signed [DiscWidth-1:0] disc_d, disc_q;
  side_t                       side_q;

  logic signed [CoordWidth-1:0] from_v [3];
  logic signed [CoordWidth-1:0] to_v   [3];

  assign from_v[0] = item_i.from_x;
  assign from_v[1] = item_i.from_y;
  assign from_v[2] = item_i.from_z;
  assign to_v[0]   = item_i.to_x;
  assign to_v[1]   = item_i.to_y;
  assign to_v[2]   = item_i.to_z;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      d_q[k]  <= DifWidth'(to_v[k]) - DifWidth'(from_v[k]);
      s_q[k]  <= from_v[k];
      dd_q[k] <= d_q[k] * d_q[k];
      ds_q[k] <= d_q[k] * s_q[k];
      ss_q[k] <= s_q[k] * s_q[k];
    end
    r_q  <= radius_i;
    rr_q <= RrWidth'(r_q) * RrWidth'(r_q);

    a_q <= AWidth'(dd_q[0]) + AWidth'(dd_q[1]) + AWidth'(dd_q[2]);
    h_q <= HWidth'(ds_q[0]) + HWidth'(ds_q[1]) + HWidth'(ds_q[2]);
    c_q <= CWidth'(ss_q[0]) + CWidth'(ss_q[1]) + CWidth'(ss_q[2])
         - CWidth'(signed'({1'b0, rr_q}));

    hh_q <= h_q * h_q;
    ac_q <= a_q * c_q;
    a4_q <= a_q;
    h4_q <= h_q;

    disc_q       <= disc_d;
    side_q.h     <= h4_q;
    side_q.a     <= a4_q;
    side_q.neg   <= disc_d[DiscWidth-1];
    side_q.azero <= (a4_q == '0);
  end

  assign disc_d  = DiscWidth'(hh_q) - DiscWidth'(ac_q);
  assign valid_o = vld_q[4];
  assign disc_o  = SqWidth'($unsigned(disc_q));
  assign side_o  = side_q;

endmodule

FILE: design/sos_isqrt.sv
// ----------------------------------------------------------------------------
// sos_isqrt: pipelined floor square root
// Restoring digit recurrence, one root bit per register stage.
// ----------------------------------------------------------------------------
module sos_isqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic [sos_pkg::SqWidth-1:0]   rad_i,
  input  sos_pkg::side_t                side_i,
  output logic                          valid_o,
  output logic [sos_pkg::RootWidth-1:0] root_o,
  output sos_pkg::side_t                side_o
);
  import sos_pkg::*;

  logic [RootWidth-1:0] vld_q;
  logic [RootWidth+1:0] rem_q  [RootWidth];
  logic [RootWidth-1:0] root_q [RootWidth];
  logic [SqWidth-1:0]   rad_q  [RootWidth];
  side_t                side_q [RootWidth];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[RootWidth-2:0], valid_i};
    end
  end

  for (genvar i = 0; i < RootWidth; i++) begin : g_stage
    logic [RootWidth+1:0] rem_in, rem_sh, trial;
    logic [RootWidth-1:0] root_in;
    logic [SqWidth-1:0]   rad_in;
    side_t                side_in;
    logic                 ge;

    if (i == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
      assign rad_in  = rad_q[i-1];
      assign side_in = side_q[i-1];
    end

    assign rem_sh = {rem_in[RootWidth-1:0], rad_in[SqWidth-1 -: 2]};
    assign trial  = {root_in, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk_i) begin
      rem_q[i]  <= ge ? (rem_sh - trial) : rem_sh;
      root_q[i] <= {root_in[RootWidth-2:0], ge};
      rad_q[i]  <= {rad_in[SqWidth-3:0], 2'b00};
      side_q[i] <= side_in;
    end
  end

  assign valid_o = vld_q[RootWidth-1];
  assign root_o  = root_q[RootWidth-1];
  assign side_o  = side_q[RootWidth-1];

endmodule

FILE: design/sphere_occlusion_test.sv
// ----------------------------------------------------------------------------
// sphere_occlusion_test: does a sphere at the origin block a segment
// Exact fixed-point ray and sphere test with a pipelined square root.
// ----------------------------------------------------------------------------
// Usage: drive a beat on in_i with start_i high; it is taken at that edge.
// busy_o is always low, so a new beat may be taken in every cycle.
// Each beat yields one result beat on res_o, marked by done_o for exactly
// one cycle; the receiver cannot stall and results leave in input order.
// Five stages form the products and the discriminant, RootWidth stages
// (one per root bit) take the square root, and two stages form and compare
// the root numerator. Throughput is one beat per cycle.
// The radius register is written with cfg_we_i and cfg_wdata_i; the user
// must write it only while no beat is in flight, which the block does not
// enforce. Reset sets it to 1.0 (256) and empties the pipeline.
// ----------------------------------------------------------------------------
module sphere_occlusion_test (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  sos_pkg::in_t                    in_i,
  output logic                            done_o,
  output sos_pkg::out_t                   res_o,
  input  logic                            cfg_we_i,
  input  logic [sos_pkg::RadiusWidth-1:0] cfg_wdata_i
);
  import sos_pkg::*;

  logic [RadiusWidth-1:0] radius_q;
  logic                   fr_valid, sq_valid;
  logic [SqWidth-1:0]     fr_disc;
  side_t                  fr_side, sq_side;
  logic [RootWidth-1:0]   sq_root;

  logic                       f1_vld_q, f2_vld_q;
  logic signed [NumWidth-1:0] num1_q, num2_q, a1_q;
  logic                       neg1_q, azero1_q;
  out_t                       res_q;
  logic signed [NumWidth-1:0] q_ext, h_ext;
  logic                       eq, gt1, gt2;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RadiusReset;
      f1_vld_q <= 1'b0;
      f2_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        radius_q <= cfg_wdata_i;
      end
      f1_vld_q <= sq_valid;
      f2_vld_q <= f1_vld_q;
    end
  end

  sos_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (start_i),
    .item_i   (in_i),
    .radius_i (radius_q),
    .valid_o  (fr_valid),
    .disc_o   (fr_disc),
    .side_o   (fr_side)
  );

  sos_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fr_valid),
    .rad_i   (fr_disc),
    .side_i  (fr_side),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  assign q_ext = NumWidth'(signed'({1'b0, sq_root}));
  assign h_ext = NumWidth'(sq_side.h);

  // Both root numerators are formed; the second one is used only when the
  // first equals a exactly.
  always_ff @(posedge clk_i) begin
    num1_q   <= q_ext - h_ext;
    num2_q   <= -h_ext - q_ext;
    a1_q     <= NumWidth'(sq_side.a);
    neg1_q   <= sq_side.neg;
    azero1_q <= sq_side.azero;
  end

  assign eq  = (num1_q == a1_q);
  assign gt1 = (num1_q > a1_q);
  assign gt2 = (num2_q > a1_q);

  always_ff @(posedge clk_i) begin
    res_q.misses_sphere <= neg1_q;
    if (neg1_q) begin
      res_q.passes <= 1'b1;
    end else if (azero1_q) begin
      res_q.passes <= 1'b0;
    end else begin
      res_q.passes <= eq ? gt2 : gt1;
    end
  end

  assign done_o = f2_vld_q;
  assign res_o  = res_q;

endmodule
